@@ sv/rgbyuv_pkg.sv @@
// Shared types and constants for the RGB to Y'CbCr 4:2:0 converter.
// Used by every converter module of the block; depends on nothing.

package rgbyuv_pkg;

    // Line geometry limits
    localparam int MAX_LINE_WIDTH   = 4096;
    localparam int MAX_FRAME_HEIGHT = 4096;
    localparam int COL_W            = $clog2(MAX_LINE_WIDTH);
    localparam int ROW_W            = $clog2(MAX_FRAME_HEIGHT);
    localparam int LINE_ENTRIES     = MAX_LINE_WIDTH / 2;
    localparam int LINE_AW          = COL_W - 1;

    // Configuration port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     RST_LINE_WIDTH   = 13'd640;
    localparam logic [CFG_W-1:0]     RST_FRAME_HEIGHT = 13'd480;

    // Luma coefficients (13 fractional bits)
    localparam int Y_KR   = 2104;
    localparam int Y_KG   = 4130;
    localparam int Y_KB   = 802;
    localparam int Y_BIAS = 4096 + 131072;
    localparam int Y_MAX  = 235;

    // Chroma coefficients (13 fractional bits), signs applied in the datapath
    localparam int CB_KR  = 1214;
    localparam int CB_KG  = 2384;
    localparam int CB_KB  = 3598;
    localparam int CR_KR  = 3598;
    localparam int CR_KG  = 3013;
    localparam int CR_KB  = 585;
    localparam int C_BIAS = 4096 + 1048576;
    localparam int C_MIN  = 16;
    localparam int C_MAX  = 240;

    // One RGB pixel, red in the low byte
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    // Sums of two samples per component
    typedef struct packed {
        logic [8:0] red;
        logic [8:0] green;
        logic [8:0] blue;
    } t_sum3;

    // Per-pixel control that rides along the pipeline
    typedef struct packed {
        logic chroma;
        logic last;
    } t_pix_ctl;

endpackage

@@ sv/rgbyuv_front.sv @@
// Raster position counters, horizontal pair sums and the even-row line buffer.
// Depends on rgbyuv_pkg.

module rgbyuv_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_accept,
    input  rgbyuv_pkg::t_rgb              i_pixel,
    input  logic [rgbyuv_pkg::COL_W-1:0]  i_wlast,
    input  logic [rgbyuv_pkg::ROW_W-1:0]  i_hlast,
    output rgbyuv_pkg::t_rgb              o_pixel,
    output rgbyuv_pkg::t_sum3             o_pair,
    output rgbyuv_pkg::t_sum3             o_entry,
    output rgbyuv_pkg::t_pix_ctl          o_ctl
);

    logic [rgbyuv_pkg::COL_W-1:0]   r_col;
    logic [rgbyuv_pkg::ROW_W-1:0]   r_row;
    rgbyuv_pkg::t_rgb               r_held;
    logic [rgbyuv_pkg::COL_W-1:0]   col_cur;
    logic [rgbyuv_pkg::ROW_W-1:0]   row_cur;
    logic [rgbyuv_pkg::COL_W-1:0]   n_col;
    logic [rgbyuv_pkg::ROW_W-1:0]   n_row;
    logic                           col_end;
    logic                           row_end;
    logic [rgbyuv_pkg::LINE_AW-1:0] line_addr;
    rgbyuv_pkg::t_sum3              pair_sum;

    logic [$bits(rgbyuv_pkg::t_sum3)-1:0] r_line_mem [rgbyuv_pkg::LINE_ENTRIES];
    rgbyuv_pkg::t_sum3              r_entry;
    rgbyuv_pkg::t_rgb               r_pixel;
    rgbyuv_pkg::t_sum3              r_pair;
    rgbyuv_pkg::t_pix_ctl           r_ctl;

    // Restart a position that lies beyond the current frame size
    always_comb begin
        col_cur = (r_col > i_wlast) ? '0 : r_col;
        row_cur = (r_row > i_hlast) ? '0 : r_row;
        col_end = (col_cur == i_wlast);
        row_end = (row_cur == i_hlast);
        n_col   = col_end ? '0 : col_cur + 1'b1;
        if (col_end) begin
            n_row = row_end ? '0 : row_cur + 1'b1;
        end else begin
            n_row = row_cur;
        end
        line_addr = col_cur[rgbyuv_pkg::COL_W-1:1];
    end

    // Add the held even-column pixel to the current one
    always_comb begin
        pair_sum.red   = {1'b0, i_pixel.red}   + {1'b0, r_held.red};
        pair_sum.green = {1'b0, i_pixel.green} + {1'b0, r_held.green};
        pair_sum.blue  = {1'b0, i_pixel.blue}  + {1'b0, r_held.blue};
    end

    // Advance position and hold even-column pixels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
            if (!col_cur[0]) begin
                r_held <= i_pixel;
            end
        end
    end

    // Line buffer: write pair sums on even rows, prefetch at the even column
    always_ff @(posedge i_clk) begin
        if (i_accept && col_cur[0] && !row_cur[0]) begin
            r_line_mem[line_addr] <= pair_sum;
        end
        if (i_accept && !col_cur[0]) begin
            r_entry <= r_line_mem[line_addr];
        end
    end

    // First pipeline register
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pixel    <= i_pixel;
            r_pair     <= pair_sum;
            r_ctl.chroma <= col_cur[0] & row_cur[0];
            r_ctl.last   <= col_end & row_end;
        end
    end

    assign o_pixel = r_pixel;
    assign o_pair  = r_pair;
    assign o_entry = r_entry;
    assign o_ctl   = r_ctl;

endmodule

@@ sv/rgbyuv_calc.sv @@
// Luma, block averages and Cb/Cr arithmetic over two register stages.
// Depends on rgbyuv_pkg.

module rgbyuv_calc (
    input  logic                 i_clk,
    input  logic                 i_adv,
    input  rgbyuv_pkg::t_rgb     i_pixel,
    input  rgbyuv_pkg::t_sum3    i_pair,
    input  rgbyuv_pkg::t_sum3    i_entry,
    input  rgbyuv_pkg::t_pix_ctl i_ctl,
    output logic [7:0]           o_luma,
    output logic                 o_chroma_valid,
    output logic [7:0]           o_chroma_blue,
    output logic [7:0]           o_chroma_red,
    output logic                 o_frame_last
);

    logic [20:0]          luma_sum;
    logic [7:0]           luma_val;
    logic [9:0]           blk_r;
    logic [9:0]           blk_g;
    logic [9:0]           blk_b;
    rgbyuv_pkg::t_rgb     avg;

    logic [7:0]           r_luma;
    rgbyuv_pkg::t_rgb     r_avg;
    rgbyuv_pkg::t_pix_ctl r_ctl;

    logic [21:0]          cb_sum;
    logic [21:0]          cr_sum;
    logic [8:0]           cb_raw;
    logic [8:0]           cr_raw;
    logic [7:0]           cb_val;
    logic [7:0]           cr_val;

    logic [7:0]           r_out_luma;
    logic                 r_out_valid;
    logic [7:0]           r_out_cb;
    logic [7:0]           r_out_cr;
    logic                 r_out_last;

    // Luma with upper clamp
    always_comb begin
        luma_sum = 21'(i_pixel.red)   * 21'(rgbyuv_pkg::Y_KR)
                 + 21'(i_pixel.green) * 21'(rgbyuv_pkg::Y_KG)
                 + 21'(i_pixel.blue)  * 21'(rgbyuv_pkg::Y_KB)
                 + 21'(rgbyuv_pkg::Y_BIAS);
        luma_val = luma_sum[20:13];
        if (luma_val > 8'(rgbyuv_pkg::Y_MAX)) begin
            luma_val = 8'(rgbyuv_pkg::Y_MAX);
        end
    end

    // Rounded 2x2 averages from this row's pair and the stored pair above
    always_comb begin
        blk_r = 10'(i_pair.red)   + 10'(i_entry.red)   + 10'd2;
        blk_g = 10'(i_pair.green) + 10'(i_entry.green) + 10'd2;
        blk_b = 10'(i_pair.blue)  + 10'(i_entry.blue)  + 10'd2;
        avg.red   = blk_r[9:2];
        avg.green = blk_g[9:2];
        avg.blue  = blk_b[9:2];
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_luma <= luma_val;
            r_avg  <= avg;
            r_ctl  <= i_ctl;
        end
    end

    // Cb and Cr; the bias keeps both sums positive over all averages
    always_comb begin
        cb_sum = 22'(rgbyuv_pkg::C_BIAS) + 22'(r_avg.blue) * 22'(rgbyuv_pkg::CB_KB)
               - 22'(r_avg.red)   * 22'(rgbyuv_pkg::CB_KR)
               - 22'(r_avg.green) * 22'(rgbyuv_pkg::CB_KG);
        cr_sum = 22'(rgbyuv_pkg::C_BIAS) + 22'(r_avg.red) * 22'(rgbyuv_pkg::CR_KR)
               - 22'(r_avg.green) * 22'(rgbyuv_pkg::CR_KG)
               - 22'(r_avg.blue)  * 22'(rgbyuv_pkg::CR_KB);
        cb_raw = cb_sum[21:13];
        cr_raw = cr_sum[21:13];

        if (cb_raw < 9'(rgbyuv_pkg::C_MIN)) begin
            cb_val = 8'(rgbyuv_pkg::C_MIN);
        end else if (cb_raw > 9'(rgbyuv_pkg::C_MAX)) begin
            cb_val = 8'(rgbyuv_pkg::C_MAX);
        end else begin
            cb_val = cb_raw[7:0];
        end

        if (cr_raw < 9'(rgbyuv_pkg::C_MIN)) begin
            cr_val = 8'(rgbyuv_pkg::C_MIN);
        end else if (cr_raw > 9'(rgbyuv_pkg::C_MAX)) begin
            cr_val = 8'(rgbyuv_pkg::C_MAX);
        end else begin
            cr_val = cr_raw[7:0];
        end
    end

    // Result register; chroma reads zero outside block-completing pixels
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_out_luma  <= r_luma;
            r_out_valid <= r_ctl.chroma;
            r_out_cb    <= r_ctl.chroma ? cb_val : '0;
            r_out_cr    <= r_ctl.chroma ? cr_val : '0;
            r_out_last  <= r_ctl.last;
        end
    end

    assign o_luma         = r_out_luma;
    assign o_chroma_valid = r_out_valid;
    assign o_chroma_blue  = r_out_cb;
    assign o_chroma_red   = r_out_cr;
    assign o_frame_last   = r_out_last;

endmodule

@@ sv/rgb_to_yuv420_converter_core.sv @@
// Top level of the RGB to Y'CbCr 4:2:0 converter: config registers, stream
// handshake and pipeline valids. Depends on rgbyuv_pkg, rgbyuv_front, rgbyuv_calc.
//
//  channel   dir  signals                         contents
//  --------  ---  ------------------------------  ---------------------------------
//  s pixel   in   i_s_tvalid/o_s_tready/i_s_tdata  red, green, blue
//  m result  out  o_m_tvalid/i_m_tready/o_m_tdata  luma, Cb, Cr; tuser chroma flag,
//                 o_m_tuser/o_m_tlast              tlast on last frame pixel
//  config    in   i_cfg_we/i_cfg_idx/i_cfg_data    line_width, frame_height
//
//  One pixel per clock while the result side does not stall; an accepted request
//  passes the front register, average/luma register and result register in turn.
//  Reset clears position counters, held pixel and pipeline valids; the line
//  buffer is not cleared. A stall on the result side freezes the whole pipeline
//  and drops o_s_tready in the same cycle.

module rgb_to_yuv420_converter_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [23:0]                          i_s_tdata,  // red, green, blue
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [23:0]                          o_m_tdata,  // luma, chroma_blue, chroma_red
    output logic [0:0]                           o_m_tuser,  // chroma_valid
    output logic                                 o_m_tlast,
    input  logic                                 i_cfg_we,
    input  logic [rgbyuv_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rgbyuv_pkg::CFG_W-1:0]         i_cfg_data
);

    logic [rgbyuv_pkg::CFG_W-1:0] r_line_width;
    logic [rgbyuv_pkg::CFG_W-1:0] r_frame_height;
    logic [rgbyuv_pkg::COL_W-1:0] wlast;
    logic [rgbyuv_pkg::ROW_W-1:0] hlast;
    logic                         adv;
    logic                         accept;
    logic                         r_v1;
    logic                         r_v2;
    logic                         r_v3;
    rgbyuv_pkg::t_rgb             pixel;
    rgbyuv_pkg::t_rgb             s1_pixel;
    rgbyuv_pkg::t_sum3            s1_pair;
    rgbyuv_pkg::t_sum3            s1_entry;
    rgbyuv_pkg::t_pix_ctl         s1_ctl;
    logic [7:0]                   luma;
    logic                         chroma_valid;
    logic [7:0]                   chroma_blue;
    logic [7:0]                   chroma_red;
    logic                         frame_last;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= rgbyuv_pkg::RST_LINE_WIDTH;
            r_frame_height <= rgbyuv_pkg::RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rgbyuv_pkg::CFG_LINE_WIDTH: begin
                    r_line_width <= i_cfg_data;
                end
                rgbyuv_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data;
                end
            endcase
        end
    end

    // Last column and row index; zero acts as one, oversize is capped
    always_comb begin
        if (r_line_width == '0) begin
            wlast = '0;
        end else if (r_line_width > rgbyuv_pkg::CFG_W'(rgbyuv_pkg::MAX_LINE_WIDTH)) begin
            wlast = rgbyuv_pkg::COL_W'(rgbyuv_pkg::MAX_LINE_WIDTH - 1);
        end else begin
            wlast = rgbyuv_pkg::COL_W'(r_line_width - 1'b1);
        end

        if (r_frame_height == '0) begin
            hlast = '0;
        end else if (r_frame_height > rgbyuv_pkg::CFG_W'(rgbyuv_pkg::MAX_FRAME_HEIGHT)) begin
            hlast = rgbyuv_pkg::ROW_W'(rgbyuv_pkg::MAX_FRAME_HEIGHT - 1);
        end else begin
            hlast = rgbyuv_pkg::ROW_W'(r_frame_height - 1'b1);
        end
    end

    // Whole pipeline advances unless the result register is held
    assign adv    = !r_v3 || i_m_tready;
    assign accept = i_s_tvalid && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        pixel.red   = i_s_tdata[7:0];
        pixel.green = i_s_tdata[15:8];
        pixel.blue  = i_s_tdata[23:16];
    end

    rgbyuv_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_accept (accept),
        .i_pixel  (pixel),
        .i_wlast  (wlast),
        .i_hlast  (hlast),
        .o_pixel  (s1_pixel),
        .o_pair   (s1_pair),
        .o_entry  (s1_entry),
        .o_ctl    (s1_ctl)
    );

    rgbyuv_calc u_calc (
        .i_clk          (i_clk),
        .i_adv          (adv),
        .i_pixel        (s1_pixel),
        .i_pair         (s1_pair),
        .i_entry        (s1_entry),
        .i_ctl          (s1_ctl),
        .o_luma         (luma),
        .o_chroma_valid (chroma_valid),
        .o_chroma_blue  (chroma_blue),
        .o_chroma_red   (chroma_red),
        .o_frame_last   (frame_last)
    );

    assign o_s_tready = adv;
    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = {chroma_red, chroma_blue, luma};
    assign o_m_tuser  = chroma_valid;
    assign o_m_tlast  = frame_last;

endmodule

@@ sv/rgbyuv_checker.sv @@
// Port-level checks for rgb_to_yuv420_converter_core and the bind that attaches them.
// Depends on rgb_to_yuv420_converter_core.

module rgbyuv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic [0:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // Drop results after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // Luma stays in the video range
    a_luma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[7:0] >= 8'd16 && o_m_tdata[7:0] <= 8'd235)
        else $error("luma out of range");

    // Chroma is clamped when present and zero otherwise
    a_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[15:8] >= 8'd16 && o_m_tdata[15:8] <= 8'd240
            && o_m_tdata[23:16] >= 8'd16 && o_m_tdata[23:16] <= 8'd240)
        else $error("chroma out of range");

    a_nochroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata[23:8] == 16'd0)
        else $error("chroma present without a finished block");

endmodule

bind rgb_to_yuv420_converter_core rgbyuv_checker u_rgbyuv_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
